// File: sv/hts_pkg.sv
// Package for the hybrid task scheduler: request, result and error codes,
// sequencer state encoding, configuration indices, reset and limit constants. No dependencies.
package hts_pkg;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DEL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    CFG_ERROR_HOLD    = 2'd0,
    CFG_REPORT_ENABLE = 2'd1
  } cfg_e;

  localparam logic [12:0] ErrorHoldReset = 13'd6000;
  localparam logic [7:0]  PendingMax     = 8'hff;

endpackage

// File: sv/hybrid_task_scheduler_unit.sv
// Hybrid time-triggered task scheduler: slot table, walk sequencer and a single
// shared increment/decrement unit. Depends on hts_pkg.
//
// One word is taken at a time; s_axis_tready is high only while the block is idle.
// A delete replies without a walk, an add walks to the first free slot and a tick
// or dispatch walks every slot; one slot is visited per cycle while the output
// register is free, and every counter update in the walk goes through the one
// shared 16-bit incrementer. Each result leaves through a one-word output register;
// the walk pauses while that register holds a word the sink has not taken. A tick
// gives one run word per due preemptive task then a done word; a dispatch gives one
// run word per pending cooperative task then a done word; add and delete give a
// single reply. The final word of each request carries tlast.
module hybrid_task_scheduler_unit
  import hts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: task_handle[15:0], task_arg[23:16], first_delay[39:24],
  //        run_period[55:40], cooperative[56], slot[59:57], zero[63:60]
  input  logic [63:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_slot[3:0], out_handle[19:4], out_arg[27:20], ok[28],
  //        error_code[30:29], zero[31]
  output logic [31:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  // slot table
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [15:0] handle_q [NUM_SLOTS];
  logic [7:0]  arg_q    [NUM_SLOTS];
  logic [15:0] delay_q  [NUM_SLOTS];
  logic [15:0] period_q [NUM_SLOTS];
  logic        coop_q   [NUM_SLOTS];
  logic [7:0]  pend_q   [NUM_SLOTS];

  // latched request
  req_e        req_q, req_d;
  logic [15:0] rq_handle_q, rq_handle_d;
  logic [7:0]  rq_arg_q, rq_arg_d;
  logic [15:0] rq_delay_q, rq_delay_d;
  logic [15:0] rq_period_q, rq_period_d;
  logic        rq_coop_q, rq_coop_d;
  logic [2:0]  rq_slot_q, rq_slot_d;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [1:0]  err_lat_q, err_lat_d;
  logic [1:0]  err_rep_q, err_rep_d;
  logic [12:0] hold_q, hold_d;
  logic [12:0] err_hold_q;
  logic        report_en_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [15:0] out_handle_q, out_handle_d;
  logic [7:0]  out_arg_q, out_arg_d;
  logic        out_ok_q, out_ok_d;
  logic [1:0]  out_err_q;
  logic        out_last_q, out_last_d;
  logic        out_load;
  logic        out_free;

  // table write strobes
  logic            add_we;
  logic            delay_we, pend_we;
  logic [15:0]     delay_wd;
  logic [7:0]      pend_wd;
  logic [IdxW-1:0] wr_idx;

  // shared incrementer
  logic [15:0] au_a, au_res;
  logic        au_inc;

  logic        cur_used, cur_coop;
  logic [15:0] cur_delay, cur_period;
  logic [7:0]  cur_pend;
  logic [15:0] cur_handle;
  logic [7:0]  cur_arg;
  logic        last_idx;

  logic [5:0]      del_slot;
  logic            del_in_range;
  logic [IdxW-1:0] del_idx;

  assign au_res = au_a + (au_inc ? 16'h0001 : 16'hffff);

  assign cur_used   = used_q[idx_q];
  assign cur_coop   = coop_q[idx_q];
  assign cur_delay  = delay_q[idx_q];
  assign cur_period = period_q[idx_q];
  assign cur_pend   = pend_q[idx_q];
  assign cur_handle = handle_q[idx_q];
  assign cur_arg    = arg_q[idx_q];
  assign last_idx   = (idx_q == LastIdx);

  assign del_slot     = {3'b000, rq_slot_q};
  assign del_in_range = (del_slot < 6'(NUM_SLOTS));
  assign del_idx      = IdxW'(del_slot);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_err_q, out_ok_q, out_arg_q, out_handle_q, out_slot_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_d       = req_q;
    rq_handle_d = rq_handle_q;
    rq_arg_d    = rq_arg_q;
    rq_delay_d  = rq_delay_q;
    rq_period_d = rq_period_q;
    rq_coop_d   = rq_coop_q;
    rq_slot_d   = rq_slot_q;
    used_d      = used_q;
    err_lat_d   = err_lat_q;
    err_rep_d   = err_rep_q;
    hold_d      = hold_q;
    add_we      = 1'b0;
    delay_we    = 1'b0;
    pend_we     = 1'b0;
    delay_wd    = au_res;
    pend_wd     = au_res[7:0];
    wr_idx      = idx_q;
    au_a        = 16'd0;
    au_inc      = 1'b0;
    out_load    = 1'b0;
    out_kind_d  = KIND_DONE;
    out_slot_d  = 4'd0;
    out_handle_d = 16'd0;
    out_arg_d   = 8'd0;
    out_ok_d    = 1'b0;
    out_last_d  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d       = req_e'(s_axis_tuser);
          rq_handle_d = s_axis_tdata[15:0];
          rq_arg_d    = s_axis_tdata[23:16];
          rq_delay_d  = s_axis_tdata[39:24];
          rq_period_d = s_axis_tdata[55:40];
          rq_coop_d   = s_axis_tdata[56];
          rq_slot_d   = s_axis_tdata[59:57];
          idx_d       = '0;
          state_d     = (req_e'(s_axis_tuser) == REQ_DELETE) ? S_DEL : S_WALK;
        end
      end

      S_DEL: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_DEL;
          out_slot_d = {1'b0, rq_slot_q};
          out_ok_d   = del_in_range && used_q[del_idx];
          if (!(del_in_range && used_q[del_idx])) err_lat_d = ERR_EMPTY;
          if (del_in_range) used_d[del_idx] = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_WALK: begin
        if (out_free) begin
          case (req_q)
            REQ_ADD: begin
              if (!cur_used) begin
                add_we         = 1'b1;
                used_d[idx_q]  = 1'b1;
                out_load       = 1'b1;
                out_kind_d     = KIND_ADD;
                out_slot_d     = 4'(idx_q);
                out_ok_d       = 1'b1;
                state_d        = S_IDLE;
              end else if (last_idx) begin
                err_lat_d  = ERR_FULL;
                out_load   = 1'b1;
                out_kind_d = KIND_ADD;
                out_slot_d = 4'(NUM_SLOTS);
                state_d    = S_IDLE;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end

            REQ_TICK: begin
              if (cur_used) begin
                if (cur_delay != 16'd0) begin
                  au_a     = cur_delay;
                  delay_we = 1'b1;
                end else begin
                  if (cur_coop) begin
                    if (cur_pend != PendingMax) begin
                      au_a    = {8'd0, cur_pend};
                      au_inc  = 1'b1;
                      pend_we = 1'b1;
                    end
                  end else begin
                    out_load     = 1'b1;
                    out_kind_d   = KIND_RUN;
                    out_slot_d   = 4'(idx_q);
                    out_handle_d = cur_handle;
                    out_arg_d    = cur_arg;
                    out_last_d   = 1'b0;
                    if (cur_period == 16'd0) used_d[idx_q] = 1'b0;
                  end
                  if (cur_period != 16'd0) begin
                    delay_we = 1'b1;
                    delay_wd = cur_period;
                  end
                end
              end
              if (last_idx) state_d = S_FIN;
              else idx_d = idx_q + 1'b1;
            end

            default: begin
              // dispatch
              if (cur_used && cur_coop && (cur_pend != 8'd0)) begin
                au_a         = {8'd0, cur_pend};
                pend_we      = 1'b1;
                out_load     = 1'b1;
                out_kind_d   = KIND_RUN;
                out_slot_d   = 4'(idx_q);
                out_handle_d = cur_handle;
                out_arg_d    = cur_arg;
                out_last_d   = 1'b0;
                if ((cur_period == 16'd0) && (cur_pend == 8'd1)) used_d[idx_q] = 1'b0;
              end
              if (last_idx) state_d = S_FIN;
              else idx_d = idx_q + 1'b1;
            end
          endcase
        end
      end

      S_FIN: begin
        if (out_free) begin
          if ((req_q == REQ_DISPATCH) && report_en_q) begin
            if (err_lat_q != err_rep_q) begin
              err_rep_d = err_lat_q;
              hold_d    = (err_lat_q != ERR_NONE) ? err_hold_q : 13'd0;
            end else if (hold_q != 13'd0) begin
              au_a   = {3'd0, hold_q};
              hold_d = au_res[12:0];
              if (hold_q == 13'd1) err_lat_d = ERR_NONE;
            end
          end
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      err_lat_q   <= ERR_NONE;
      err_rep_q   <= ERR_NONE;
      hold_q      <= 13'd0;
      err_hold_q  <= ErrorHoldReset;
      report_en_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      used_q    <= used_d;
      err_lat_q <= err_lat_d;
      err_rep_q <= err_rep_d;
      hold_q    <= hold_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ERROR_HOLD) err_hold_q <= cfg_data_i[12:0];
        if (cfg_index_i == CFG_REPORT_ENABLE) report_en_q <= cfg_data_i[0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rq_handle_q <= rq_handle_d;
    rq_arg_q    <= rq_arg_d;
    rq_delay_q  <= rq_delay_d;
    rq_period_q <= rq_period_d;
    rq_coop_q   <= rq_coop_d;
    rq_slot_q   <= rq_slot_d;
    if (add_we) begin
      handle_q[wr_idx] <= rq_handle_q;
      arg_q[wr_idx]    <= rq_arg_q;
      delay_q[wr_idx]  <= rq_delay_q;
      period_q[wr_idx] <= rq_period_q;
      coop_q[wr_idx]   <= rq_coop_q;
      pend_q[wr_idx]   <= 8'd0;
    end else begin
      if (delay_we) delay_q[wr_idx] <= delay_wd;
      if (pend_we) pend_q[wr_idx] <= pend_wd;
    end
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_slot_q   <= out_slot_d;
      out_handle_q <= out_handle_d;
      out_arg_q    <= out_arg_d;
      out_ok_q     <= out_ok_d;
      out_last_q   <= out_last_d;
      // error field reflects the latch after this step's update, or none if reporting is off
      out_err_q    <= report_en_q ? err_lat_d : ERR_NONE;
    end
  end

endmodule
